>>> rtl/core/bkst_pkg.sv
// ----------------------------------------------------------------------------
// bkst_pkg
// Shared types and constants for the bounded key set table.
// ----------------------------------------------------------------------------
package bkst_pkg;

	localparam int KEY_W   = 64;
	localparam int COUNT_W = 9;

	typedef logic [1:0] action_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_REMOVE = 2'd1;
	localparam action_t ACT_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_MOVE,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/core/bkst_key_ram.sv
// ----------------------------------------------------------------------------
// bkst_key_ram
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bkst_key_ram
	import bkst_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [KEY_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/core/bounded_key_set_table_top.sv
// ----------------------------------------------------------------------------
// bounded_key_set_table_top
// Dense set of 64-bit keys with linear search, append on insert and
// swap-with-last on remove. One result per request.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | action[1:0], key[63:0]
//  out     | out_valid / out_ready| was_present, dropped, entry_count[8:0]
//
//  A request passes through the scan, apply and finish states; a remove that
//  hits adds a move state between apply and finish. A hit ends the scan at
//  the matching key, while a miss reads every held key. The scan reads one
//  entry a cycle through the single RAM read port.
//  Reset empties the set at once; the key RAM itself is never cleared.
//  The result waits in an output register, so a new request is taken while
//  it stalls; the next result is held back until that register is free.
// ----------------------------------------------------------------------------
module bounded_key_set_table_top
	import bkst_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [KEY_W-1:0]   key,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_present,
	output logic               dropped,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic               pend_s1;
	logic [AW-1:0]      cmp_idx_s1;
	logic [KEY_W-1:0]   rd_data_s1;
	action_t            action_q;
	logic [KEY_W-1:0]   key_q;
	logic               found_q;
	logic               drop_q;
	logic [AW-1:0]      slot_q;
	logic               out_valid_q;
	logic               was_present_q;
	logic               dropped_q;
	logic [COUNT_W-1:0] entry_count_q;

	logic               hit;
	logic               issue;
	logic               scan_done;
	logic               out_free;
	logic               is_insert;
	logic               is_remove;
	logic               has_room;
	logic [CW-1:0]      count_m1;
	logic [CW+COUNT_W-1:0] count_ext;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [KEY_W-1:0]   wr_data;
	logic [AW-1:0]      rd_addr;

	assign hit       = pend_s1 && (rd_data_s1 == key_q);
	assign issue     = !hit && (idx_q < count_q);
	assign scan_done = hit || (!issue && !pend_s1);
	assign out_free  = !out_valid_q || out_ready;
	assign is_insert = (action_q == ACT_INSERT);
	assign is_remove = (action_q == ACT_REMOVE);
	assign has_room  = (count_q < CW'(CAPACITY));
	assign count_m1  = count_q - CW'(1);
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = (is_remove && found_q) ? ST_MOVE : ST_FINISH;
			end
			ST_MOVE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		in_ready = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = slot_q;
		wr_data  = rd_data_s1;
		rd_addr  = idx_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN: begin
				rd_addr = idx_q[AW-1:0];
			end
			ST_APPLY: begin
				// fetch the last entry for a swap-remove; append an insert that misses, if there is room
				rd_addr = count_m1[AW-1:0];
				if (is_insert && !found_q && has_room) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = key_q;
				end
			end
			ST_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = rd_data_s1;
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	bkst_key_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
				end
				ST_SCAN: begin
					pend_s1 <= issue;
				end
				ST_APPLY: begin
					if (is_insert && !found_q && has_room) count_q <= count_q + CW'(1);
				end
				ST_MOVE: begin
					count_q <= count_m1;
				end
				ST_FINISH: begin
					if (out_free) out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// request payload and scan bookkeeping
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					action_q <= action;
					key_q    <= key;
					idx_q    <= '0;
					found_q  <= 1'b0;
					drop_q   <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (issue) begin
					idx_q      <= idx_q + CW'(1);
					cmp_idx_s1 <= idx_q[AW-1:0];
				end
				if (hit) begin
					found_q <= 1'b1;
					slot_q  <= cmp_idx_s1;
				end
			end
			ST_APPLY: begin
				if (is_insert && !found_q && !has_room) drop_q <= 1'b1;
			end
			ST_FINISH: begin
				if (out_free) begin
					was_present_q <= found_q;
					dropped_q     <= drop_q;
					entry_count_q <= count_ext[COUNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign was_present = was_present_q;
	assign dropped     = dropped_q;
	assign entry_count = entry_count_q;

endmodule
